/* rtl/rbrc_pkg.sv */
// Shared types and codes for the ring buffer with read cursor.
package rbrc_pkg;

    localparam int unsigned DEPTH_DEFAULT = 4096;

    // Request codes
    localparam logic [2:0] REQ_PUT     = 3'd0;
    localparam logic [2:0] REQ_GET     = 3'd1;
    localparam logic [2:0] REQ_PEEK    = 3'd2;
    localparam logic [2:0] REQ_CONSUME = 3'd3;
    localparam logic [2:0] REQ_SEEK    = 3'd4;

    // Seek origins
    localparam logic [1:0] ORG_START  = 2'd0;
    localparam logic [1:0] ORG_CURSOR = 2'd1;
    localparam logic [1:0] ORG_END    = 2'd2;
    localparam logic [1:0] ORG_ABS    = 2'd3;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic load;    // capture the accepted request
        logic commit;  // update pointers, store and result register
    } ctrl_cmd_t;

endpackage

/* rtl/rbrc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rbrc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rbrc_ctrl.sv */
// Controller state machine: request acceptance, execution and result handoff.
module rbrc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rbrc_pkg::ctrl_cmd_t cmd
);

    import rbrc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            S_EXEC:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_EXEC))
        else $error("accepted request did not enter execution");

    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp_valid)
        else $error("committed request produced no result");

endmodule

/* rtl/rbrc_datapath.sv */
// Datapath: request latch, ring pointers, byte store and result register.
module rbrc_datapath #(
    parameter int unsigned DEPTH = rbrc_pkg::DEPTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rbrc_pkg::ctrl_cmd_t       cmd,
    input  logic [2:0]                req_type,
    input  logic [7:0]                data_in,
    input  logic [11:0]               count,
    input  logic [1:0]                seek_origin,
    input  logic signed [12:0]        seek_offset,
    output logic [7:0]                data_out,
    output logic                      ok,
    output logic [11:0]               position,
    output logic [11:0]               fill,
    output logic [11:0]               free_space,
    output logic [11:0]               unread
);

    import rbrc_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Latched request
    logic [2:0]  req_type_reg;
    logic [7:0]  data_in_reg;
    logic [11:0] count_reg;
    logic [1:0]  seek_origin_reg;
    logic [12:0] seek_offset_reg;

    // Ring pointers
    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] read_reg, read_next;
    logic [AW-1:0] write_reg, write_next;

    // Result register
    logic [7:0]  data_out_reg, data_out_next;
    logic        ok_reg, ok_next;
    logic [11:0] position_reg, position_next;
    logic [11:0] fill_reg, fill_next;
    logic [11:0] free_reg, free_next;
    logic [11:0] unread_reg, unread_next;

    logic [7:0]       rd_data;
    logic             mem_we;
    logic [AW-1:0]    fill_cur;
    logic             full;
    logic             empty;
    logic [AW+11:0]   cnt_wide;
    logic [AW+11:0]   fill_wide;
    logic             release_all;
    logic [AW-1:0]    cons_start;
    logic             cons_live;
    logic [AW-1:0]    seek_base;
    logic [AW+12:0]   off_wide;
    logic [AW-1:0]    seek_target;
    logic             seek_live;
    logic [AW-1:0]    fill_new;
    logic [AW-1:0]    unread_new;
    logic [AW+11:0]   pos_ext, fill_ext, free_ext, unread_ext;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg    <= req_type;
            data_in_reg     <= data_in;
            count_reg       <= count;
            seek_origin_reg <= seek_origin;
            seek_offset_reg <= seek_offset;
        end
    end

    // The store is always read at the cursor, so the byte is ready in the cycle after.
    rbrc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (write_reg),
        .wdata (data_in_reg),
        .raddr (read_reg),
        .rdata (rd_data)
    );

    assign fill_cur = write_reg - start_reg;
    assign full     = (write_reg == (start_reg - AW'(1)));
    assign empty    = (read_reg == write_reg);

    // Consume: release from the start, pull the cursor back into the live region
    assign cnt_wide    = {{AW{1'b0}}, count_reg};
    assign fill_wide   = {12'b0, fill_cur};
    assign release_all = (cnt_wide >= fill_wide);
    assign cons_start  = release_all ? write_reg : (start_reg + cnt_wide[AW-1:0]);
    assign cons_live   = ((read_reg - cons_start) <= (write_reg - cons_start));

    // Seek: target wraps modulo depth, accepted only inside the live region
    always_comb
    begin
        case (seek_origin_reg)
            ORG_START:  seek_base = start_reg;
            ORG_CURSOR: seek_base = read_reg;
            ORG_END:    seek_base = write_reg;
            ORG_ABS:    seek_base = '0;
            default:    seek_base = '0;
        endcase
    end

    assign off_wide    = {{AW{seek_offset_reg[12]}}, seek_offset_reg};
    assign seek_target = seek_base + off_wide[AW-1:0];
    assign seek_live   = ((seek_target - start_reg) <= fill_cur);

    always_comb
    begin
        start_next    = start_reg;
        read_next     = read_reg;
        write_next    = write_reg;
        mem_we        = 1'b0;
        ok_next       = 1'b0;
        data_out_next = 8'd0;
        case (req_type_reg)
            REQ_PUT:
            begin
                if (!full)
                begin
                    mem_we     = cmd.commit;
                    write_next = write_reg + AW'(1);
                    ok_next    = 1'b1;
                end
            end
            REQ_GET, REQ_PEEK:
            begin
                if (!empty)
                begin
                    data_out_next = rd_data;
                    ok_next       = 1'b1;
                    if (req_type_reg == REQ_GET)
                    begin
                        read_next = read_reg + AW'(1);
                    end
                end
            end
            REQ_CONSUME:
            begin
                start_next = cons_start;
                if (!cons_live)
                begin
                    read_next = cons_start;
                end
                ok_next = 1'b1;
            end
            REQ_SEEK:
            begin
                if (seek_live)
                begin
                    read_next = seek_target;
                    ok_next   = 1'b1;
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    assign fill_new   = write_next - start_next;
    assign unread_new = write_next - read_next;
    assign pos_ext    = {12'b0, read_next};
    assign fill_ext   = {12'b0, fill_new};
    assign free_ext   = {12'b0, ~fill_new};
    assign unread_ext = {12'b0, unread_new};

    assign position_next = pos_ext[11:0];
    assign fill_next     = fill_ext[11:0];
    assign free_next     = free_ext[11:0];
    assign unread_next   = unread_ext[11:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            read_reg  <= '0;
            write_reg <= '0;
        end
        else if (cmd.commit)
        begin
            start_reg <= start_next;
            read_reg  <= read_next;
            write_reg <= write_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            data_out_reg <= data_out_next;
            ok_reg       <= ok_next;
            position_reg <= position_next;
            fill_reg     <= fill_next;
            free_reg     <= free_next;
            unread_reg   <= unread_next;
        end
    end

    assign data_out   = data_out_reg;
    assign ok         = ok_reg;
    assign position   = position_reg;
    assign fill       = fill_reg;
    assign free_space = free_reg;
    assign unread     = unread_reg;

    a_cursor_live: assert property (@(posedge clk) disable iff (!rst_n)
        (read_reg - start_reg) <= (write_reg - start_reg))
        else $error("read cursor left the live region");

    a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> ($stable(start_reg) && $stable(read_reg) && $stable(write_reg)))
        else $error("pointers moved without a commit");

    a_put_keeps_slot: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (write_reg != start_reg))
        else $error("put overran the free slot");

endmodule

/* rtl/ring_buffer_with_read_cursor_unit.sv */
// Top level of the byte ring buffer with a seekable read cursor.
//
// A DEPTH-byte ring (DEPTH a power of two) with a committed start, a read
// cursor and a write end; one slot is always kept free, so at most DEPTH-1
// bytes are held. Each request transaction (put, get, peek, consume, seek)
// returns exactly one result transaction carrying the byte read, a success
// flag, the cursor after the request, and the fill, free space and unread
// counts. The byte store has a registered read port, so the byte at the
// cursor is registered from the store before the result is committed, and
// one request is in flight at a time. A new request is accepted while the
// previous result still waits on the output register; it then holds in
// execution until that result is taken. The store needs no clearing after
// reset: the pointer rules only read bytes that were written, and the
// block is ready right out of reset.
module ring_buffer_with_read_cursor_unit #(
    parameter int unsigned DEPTH = rbrc_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [2:0]         req_type,
    input  logic [7:0]         data_in,
    input  logic [11:0]        count,
    input  logic [1:0]         seek_origin,
    input  logic signed [12:0] seek_offset,
    // result channel
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic [7:0]         data_out,
    output logic               ok,
    output logic [11:0]        position,
    output logic [11:0]        fill,
    output logic [11:0]        free_space,
    output logic [11:0]        unread
);

    import rbrc_pkg::*;

    // Commands from the controller to the datapath
    ctrl_cmd_t cmd;

    // Controller: capture on acceptance, commit when the result slot is free
    rbrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    // Datapath: pointer arithmetic, byte store and result register
    rbrc_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req_type),
        .data_in     (data_in),
        .count       (count),
        .seek_origin (seek_origin),
        .seek_offset (seek_offset),
        .data_out    (data_out),
        .ok          (ok),
        .position    (position),
        .fill        (fill),
        .free_space  (free_space),
        .unread      (unread)
    );

endmodule

/* bench/ring_buffer_with_read_cursor_unit_tb.sv */
// Self-checking testbench for the byte ring buffer with a seekable read cursor.
`timescale 1ns / 1ps

module ring_buffer_with_read_cursor_unit_tb;

    import rbrc_pkg::*;

    // Request codes the block answers with a plain refusal.
    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_MID   = 3'd6;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

    localparam int PUT_BURST   = 40;
    localparam int RANDOM_REQS = 630;

    typedef struct {
        logic [2:0]         kind;
        logic [7:0]         byte_val;
        logic [11:0]        cnt;
        logic [1:0]         org;
        logic signed [12:0] ofs;
    } ring_req_t;

    typedef struct {
        logic [7:0]  data;
        logic        ok;
        logic [11:0] pos;
        logic [11:0] fill;
        logic [11:0] room;
        logic [11:0] unread;
    } ring_status_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic [2:0]         req_type = REQ_PUT;
    logic [7:0]         data_in = 8'd0;
    logic [11:0]        count = 12'd0;
    logic [1:0]         seek_origin = ORG_START;
    logic signed [12:0] seek_offset = 13'sd0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    logic [7:0]         data_out;
    logic               ok;
    logic [11:0]        position;
    logic [11:0]        fill;
    logic [11:0]        free_space;
    logic [11:0]        unread;

    ring_buffer_with_read_cursor_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .data_in     (data_in),
        .count       (count),
        .seek_origin (seek_origin),
        .seek_offset (seek_offset),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .data_out    (data_out),
        .ok          (ok),
        .position    (position),
        .fill        (fill),
        .free_space  (free_space),
        .unread      (unread)
    );

    // 4 ns clock: two ns high, two ns low.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Ring state mirrored by the testbench: byte store, committed start,
    // read cursor and write end, all wrapping at the ring depth.
    // ------------------------------------------------------------------
    logic [7:0]  ring_bytes [DEPTH_DEFAULT];
    logic [11:0] head_ptr = '0;
    logic [11:0] cur_ptr  = '0;
    logic [11:0] tail_ptr = '0;

    ring_req_t    pending_reqs [$];   // requests not yet offered to the block
    ring_status_t status_due [$];     // predicted results, oldest first
    int           mismatches = 0;
    int           offered = 0;        // requests put on the bus so far
    bit           req_taken = 1'b0;   // request accepted at the last rising edge

    // Live region runs from the committed start to the write end, inclusive,
    // and may wrap past the top of the ring.
    function automatic bit in_live_region(logic [11:0] p);
        if (tail_ptr >= head_ptr)
            return p >= head_ptr && p <= tail_ptr;
        return p >= head_ptr || p <= tail_ptr;
    endfunction

    // Apply one request to the mirrored ring and return the status it yields.
    function automatic ring_status_t apply_request(ring_req_t rq);
        ring_status_t st;
        logic [11:0]  base;
        logic [11:0]  target;
        logic [11:0]  held;
        st = '{data: '0, ok: 1'b0, pos: '0, fill: '0, room: '0, unread: '0};
        case (rq.kind)
            REQ_PUT:
            begin
                // One slot always stays empty: full when the write end
                // sits just behind the start.
                if (tail_ptr != head_ptr - 12'd1)
                begin
                    ring_bytes[tail_ptr] = rq.byte_val;
                    tail_ptr = tail_ptr + 12'd1;
                    st.ok = 1'b1;
                end
            end
            REQ_GET, REQ_PEEK:
            begin
                if (cur_ptr != tail_ptr)
                begin
                    st.data = ring_bytes[cur_ptr];
                    if (rq.kind == REQ_GET)
                        cur_ptr = cur_ptr + 12'd1;
                    st.ok = 1'b1;
                end
            end
            REQ_CONSUME:
            begin
                held = tail_ptr - head_ptr;
                if (rq.cnt >= held)
                    head_ptr = tail_ptr;
                else
                    head_ptr = head_ptr + rq.cnt;
                // Pull a cursor left behind by the release up to the new start.
                if (!in_live_region(cur_ptr))
                    cur_ptr = head_ptr;
                st.ok = 1'b1;
            end
            REQ_SEEK:
            begin
                case (rq.org)
                    ORG_START:  base = head_ptr;
                    ORG_CURSOR: base = cur_ptr;
                    ORG_END:    base = tail_ptr;
                    default:    base = '0;
                endcase
                // Offsets wrap modulo the depth, so the low bits are enough.
                target = base + rq.ofs[11:0];
                if (in_live_region(target))
                begin
                    cur_ptr = target;
                    st.ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        st.pos    = cur_ptr;
        st.fill   = tail_ptr - head_ptr;
        st.room   = 12'hFFF - st.fill;
        st.unread = tail_ptr - cur_ptr;
        return st;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("mismatch %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic queue_req(logic [2:0] kind, logic [7:0] byte_val, logic [11:0] cnt,
                             logic [1:0] org, logic signed [12:0] ofs);
        ring_req_t rq;
        rq.kind     = kind;
        rq.byte_val = byte_val;
        rq.cnt      = cnt;
        rq.org      = org;
        rq.ofs      = ofs;
        pending_reqs.push_back(rq);
    endtask

    // Random request: mostly puts and reads to keep data flowing, with
    // small counts and offsets so consumes and seeks land near the live
    // region, and now and then full-range values.
    task automatic queue_random_req();
        int                 pick;
        logic [2:0]         kind;
        logic [11:0]        cnt;
        logic signed [12:0] ofs;
        pick = $urandom_range(99);
        if (pick < 40)
            kind = REQ_PUT;
        else if (pick < 58)
            kind = REQ_GET;
        else if (pick < 66)
            kind = REQ_PEEK;
        else if (pick < 78)
            kind = REQ_CONSUME;
        else if (pick < 96)
            kind = REQ_SEEK;
        else
            kind = 3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST));
        if ($urandom_range(9) == 0)
            cnt = 12'($urandom_range(4095));
        else
            cnt = 12'($urandom_range(12));
        if ($urandom_range(7) == 0)
            ofs = 13'($urandom);
        else
            ofs = 13'($signed($urandom_range(16)) - 8);
        queue_req(kind, 8'($urandom_range(255)), cnt, 2'($urandom_range(3)), ofs);
    endtask

    // Hold off idling on both sides over a long stretch of the run.
    wire calm = offered >= 300 && offered < 450;

    // ------------------------------------------------------------------
    // Driver: change inputs at the falling edge. Advance to the next
    // request only once the current transaction has been accepted.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        ring_req_t nxt;
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 20))
                begin
                    nxt = pending_reqs.pop_front();
                    req_valid   <= 1'b1;
                    req_type    <= nxt.kind;
                    data_in     <= nxt.byte_val;
                    count       <= nxt.cnt;
                    seek_origin <= nxt.org;
                    seek_offset <= nxt.ofs;
                    offered++;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
            rsp_ready <= calm || $urandom_range(99) >= 20;
        end
    end

    // Request side of the bus: predict the result of each accepted request.
    always @(posedge clk)
    begin
        ring_req_t rq;
        req_taken = rst_n && req_valid && req_ready;
        if (req_taken)
        begin
            rq.kind     = req_type;
            rq.byte_val = data_in;
            rq.cnt      = count;
            rq.org      = seek_origin;
            rq.ofs      = seek_offset;
            status_due.push_back(apply_request(rq));
        end
    end

    // Monitor: compare each result transaction with the oldest prediction.
    always @(posedge clk)
    begin
        ring_status_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (status_due.size() == 0)
            begin
                flag_mismatch("unexpected result, position", position, -1);
            end
            else
            begin
                want = status_due.pop_front();
                if (data_out !== want.data)
                    flag_mismatch("data_out", data_out, want.data);
                if (ok !== want.ok)
                    flag_mismatch("ok", ok, want.ok);
                if (position !== want.pos)
                    flag_mismatch("position", position, want.pos);
                if (fill !== want.fill)
                    flag_mismatch("fill", fill, want.fill);
                if (free_space !== want.room)
                    flag_mismatch("free_space", free_space, want.room);
                if (unread !== want.unread)
                    flag_mismatch("unread", unread, want.unread);
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        // Directed: both byte extremes, each request kind, empty reads,
        // seeks to the write end and outside the live region, consumes of
        // zero, one and everything, and the spare request codes.
        queue_req(REQ_GET,     8'h00, 12'd0,    ORG_START,  13'sd0);
        queue_req(REQ_PUT,     8'h00, 12'd0,    ORG_START,  13'sd0);
        queue_req(REQ_PUT,     8'hFF, 12'hFFF,  ORG_ABS,    -13'sd4096);
        queue_req(REQ_PUT,     8'hA5, 12'd0,    ORG_START,  13'sd0);
        queue_req(REQ_PEEK,    8'h00, 12'd0,    ORG_START,  13'sd0);
        queue_req(REQ_GET,     8'h00, 12'd0,    ORG_START,  13'sd0);
        queue_req(REQ_GET,     8'h00, 12'd0,    ORG_START,  13'sd0);
        queue_req(REQ_SEEK,    8'h00, 12'd0,    ORG_END,    13'sd0);
        queue_req(REQ_GET,     8'h00, 12'd0,    ORG_START,  13'sd0);
        queue_req(REQ_PEEK,    8'h00, 12'd0,    ORG_START,  13'sd0);
        queue_req(REQ_SEEK,    8'h00, 12'd0,    ORG_CURSOR, -13'sd1);
        queue_req(REQ_SEEK,    8'h00, 12'd0,    ORG_START,  13'sd4095);
        queue_req(REQ_SEEK,    8'h00, 12'd0,    ORG_START,  -13'sd4096);
        queue_req(REQ_SEEK,    8'h00, 12'd0,    ORG_ABS,    13'sd4095);
        queue_req(REQ_SEEK,    8'h00, 12'd0,    ORG_ABS,    13'sd1);
        queue_req(REQ_CONSUME, 8'h00, 12'd0,    ORG_START,  13'sd0);
        queue_req(REQ_CONSUME, 8'h00, 12'd1,    ORG_START,  13'sd0);
        queue_req(REQ_SEEK,    8'h00, 12'd0,    ORG_START,  13'sd0);
        queue_req(REQ_CONSUME, 8'h00, 12'hFFF,  ORG_START,  13'sd0);
        queue_req(REQ_PEEK,    8'h00, 12'd0,    ORG_START,  13'sd0);
        queue_req(REQ_SPARE_FIRST, 8'h5A, 12'h555, ORG_ABS, 13'sd5);
        queue_req(REQ_SPARE_MID,   8'h00, 12'd0,   ORG_START, 13'sd0);
        queue_req(REQ_SPARE_LAST,  8'hFF, 12'hFFF, ORG_ABS,  -13'sd1);

        // Load a burst of bytes, then read, seek by large offsets from the end,
        // cursor and start origins and release with two large counts.
        repeat (PUT_BURST)
            queue_req(REQ_PUT, 8'($urandom_range(255)), 12'd0, ORG_START, 13'sd0);
        queue_req(REQ_GET,     8'h00, 12'd0,    ORG_START,  13'sd0);
        queue_req(REQ_SEEK,    8'h00, 12'd0,    ORG_END,    -13'sd4095);
        queue_req(REQ_SEEK,    8'h00, 12'd0,    ORG_CURSOR, 13'sd4095);
        queue_req(REQ_SEEK,    8'h00, 12'd0,    ORG_START,  13'sd2000);
        queue_req(REQ_PEEK,    8'h00, 12'd0,    ORG_START,  13'sd0);
        queue_req(REQ_CONSUME, 8'h00, 12'd2500, ORG_START,  13'sd0);
        queue_req(REQ_GET,     8'h00, 12'd0,    ORG_START,  13'sd0);
        queue_req(REQ_CONSUME, 8'h00, 12'd4000, ORG_START,  13'sd0);

        repeat (RANDOM_REQS)
            queue_random_req();

        // Hold reset, then release it off the rising edge.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain: every request accepted, every result back, then a short tail.
        while (pending_reqs.size() != 0 || req_valid)
            @(posedge clk);
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
